[rtl/core/ppdm_pkg.sv]
// Shared constants, types and state codes for the pulse period and duty meter.
package ppdm_pkg;

   localparam int SUM_WIDTH   = 24;
   localparam int WINDOW_W    = 8;
   localparam int TIMEOUT_W   = 24;
   localparam int SCALE_W     = 18;
   localparam int OUT_W       = 16;
   localparam int BAND_W      = 2;
   localparam int FRAC_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam int CMP_W      = (SUM_WIDTH > TIMEOUT_W) ? SUM_WIDTH : TIMEOUT_W;
   localparam int FREQ_NUM   = 1000000;
   localparam int FREQ_NUM_W = 20;
   localparam int DIV_W      = (SUM_WIDTH > FREQ_NUM_W) ? SUM_WIDTH : FREQ_NUM_W;
   localparam int DIVISOR_W  = OUT_W;
   localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
   localparam int MUL_A_W    = SUM_WIDTH + 1;
   localparam int PROD_W     = MUL_A_W + SCALE_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SUM_WIDTH-1:0] SUM_MAX       = {SUM_WIDTH{1'b1}};
   localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = 8'd10;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd655360;
   localparam logic [SCALE_W-1:0]   SCALE_RESET   = 18'd71111;
   localparam logic [OUT_W-1:0]     OUT_MAX       = {OUT_W{1'b1}};
   localparam logic [OUT_W-1:0]     LIMIT_1K      = 16'd1000;
   localparam logic [OUT_W-1:0]     LIMIT_10K     = 16'd10000;

   localparam logic [BAND_W-1:0] BAND_IN    = 2'd0;
   localparam logic [BAND_W-1:0] BAND_BELOW = 2'd1;
   localparam logic [BAND_W-1:0] BAND_ABOVE = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_PERIODS = 2'd0,
      CSR_TIMEOUT_TICKS  = 2'd1,
      CSR_TICK_SCALE     = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV_HIGH,
      BK_DIV_LOW,
      BK_MUL_PER,
      BK_MUL_HIGH,
      BK_DIV_FREQ,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic [WINDOW_W-1:0]  window_periods;
      logic [TIMEOUT_W-1:0] timeout_ticks;
      logic [SCALE_W-1:0]   tick_scale_q16;
   } cfg_type;

   typedef struct packed {
      logic                 timed_out;
      logic [SUM_WIDTH-1:0] high_sum;
      logic [SUM_WIDTH-1:0] low_sum;
   } meas_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

[rtl/core/ppdm_if.sv]
// Handshake channel interfaces for the tick input and the measurement output.
interface ppdm_req_if;
   logic valid;
   logic ready;
   logic wave_level;

   modport source (output valid, output wave_level, input ready);
   modport sink (input valid, input wave_level, output ready);
endinterface

interface ppdm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ppdm_pkg::OUT_W-1:0]    freq_hz;
   logic [ppdm_pkg::OUT_W-1:0]    period_us;
   logic [ppdm_pkg::OUT_W-1:0]    high_us;
   logic                          freq_over_1k;
   logic [ppdm_pkg::BAND_W-1:0]   freq_band;
   logic                          period_over_1ms;
   logic                          high_over_1ms;
   logic                          timed_out;

   modport source (output valid, output freq_hz, output period_us, output high_us,
                   output freq_over_1k, output freq_band, output period_over_1ms,
                   output high_over_1ms, output timed_out, input ready);
   modport sink (input valid, input freq_hz, input period_us, input high_us,
                 input freq_over_1k, input freq_band, input period_over_1ms,
                 input high_over_1ms, input timed_out, output ready);
endinterface

[rtl/core/pulse_period_duty_meter.sv]
// Top level of the averaging period and pulse width meter.
// Ticks are taken one per cycle while the measurement queue has room.
// A window result is offered once its closing edge has passed the queue and up to three passes of the
// one-bit-per-cycle divider; a timeout result passes the queue and the finish state into the output register.
// The arithmetic handles one measurement at a time; up to four more wait in the queue.
// Reset is synchronous and active high; it restores the register defaults and unsyncs.
module pulse_period_duty_meter (
   input  logic                                 clock,
   input  logic                                 reset,
   ppdm_req_if.sink                             req_chan,
   ppdm_rsp_if.source                           rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [ppdm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ppdm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ppdm_pkg::cfg_type   cfg_ff, cfg_in;
   ppdm_pkg::meas_type  push_entry;
   ppdm_pkg::meas_type  head;
   logic                push;
   logic                pop;
   logic                queue_empty;
   logic                queue_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ppdm_pkg::CSR_WINDOW_PERIODS: begin
               cfg_in.window_periods = csr_wdata[ppdm_pkg::WINDOW_W-1:0];
            end
            ppdm_pkg::CSR_TIMEOUT_TICKS: begin
               cfg_in.timeout_ticks = csr_wdata[ppdm_pkg::TIMEOUT_W-1:0];
            end
            ppdm_pkg::CSR_TICK_SCALE: begin
               cfg_in.tick_scale_q16 = csr_wdata[ppdm_pkg::SCALE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_periods <= ppdm_pkg::WINDOW_RESET;
         cfg_ff.timeout_ticks  <= ppdm_pkg::TIMEOUT_RESET;
         cfg_ff.tick_scale_q16 <= ppdm_pkg::SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppdm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   ppdm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   ppdm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .rsp         (rsp_chan)
   );

endmodule

[rtl/core/ppdm_front.sv]
// Tick counter: synchronises on rising edges, sums high and low ticks, detects window end and timeout.
module ppdm_front (
   input  logic                clock,
   input  logic                reset,
   ppdm_req_if.sink            req,
   input  ppdm_pkg::cfg_type   cfg,
   input  logic                queue_full,
   output logic                push,
   output ppdm_pkg::meas_type  push_entry
);

   logic                               last_ff, last_in;
   logic                               synced_ff, synced_in;
   logic [ppdm_pkg::SUM_WIDTH-1:0]     high_sum_ff, high_sum_in;
   logic [ppdm_pkg::SUM_WIDTH-1:0]     low_sum_ff, low_sum_in;
   logic [ppdm_pkg::WINDOW_W-1:0]      periods_ff, periods_in;

   logic                               accept;
   logic                               rise;
   logic                               window_end;
   logic [ppdm_pkg::WINDOW_W-1:0]      w_eff;
   logic [ppdm_pkg::WINDOW_W-1:0]      periods_inc;
   logic [ppdm_pkg::SUM_WIDTH-1:0]     base_high, base_low;
   logic [ppdm_pkg::SUM_WIDTH-1:0]     cnt_high, cnt_low;
   logic                               timeout_hit;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      rise        = !last_ff && req.wave_level;
      w_eff       = (cfg.window_periods == '0) ? ppdm_pkg::WINDOW_W'(1) : cfg.window_periods;
      periods_inc = periods_ff + ppdm_pkg::WINDOW_W'(1);
      window_end  = synced_ff && rise && (periods_inc >= w_eff);

      base_high = synced_ff ? high_sum_ff : '0;
      base_low  = synced_ff ? low_sum_ff : '0;
      cnt_high  = (req.wave_level && (base_high != ppdm_pkg::SUM_MAX))
                  ? base_high + ppdm_pkg::SUM_WIDTH'(1) : base_high;
      cnt_low   = (!req.wave_level && (base_low != ppdm_pkg::SUM_MAX))
                  ? base_low + ppdm_pkg::SUM_WIDTH'(1) : base_low;
      timeout_hit = (ppdm_pkg::CMP_W'(cnt_high) >= ppdm_pkg::CMP_W'(cfg.timeout_ticks))
                 || (ppdm_pkg::CMP_W'(cnt_low) >= ppdm_pkg::CMP_W'(cfg.timeout_ticks));

      last_in     = last_ff;
      synced_in   = synced_ff;
      high_sum_in = high_sum_ff;
      low_sum_in  = low_sum_ff;
      periods_in  = periods_ff;
      push        = 1'b0;
      push_entry.timed_out = 1'b0;
      push_entry.high_sum  = high_sum_ff;
      push_entry.low_sum   = low_sum_ff;

      if (accept) begin
         last_in = req.wave_level;
         if (window_end) begin
            push        = 1'b1;
            high_sum_in = ppdm_pkg::SUM_WIDTH'(1);
            low_sum_in  = '0;
            periods_in  = '0;
         end else if (synced_ff || rise) begin
            if (timeout_hit) begin
               push                 = 1'b1;
               push_entry.timed_out = 1'b1;
               push_entry.high_sum  = '0;
               push_entry.low_sum   = '0;
               synced_in            = 1'b0;
               high_sum_in          = '0;
               low_sum_in           = '0;
               periods_in           = '0;
            end else begin
               synced_in   = 1'b1;
               high_sum_in = cnt_high;
               low_sum_in  = cnt_low;
               periods_in  = !synced_ff ? '0 : (rise ? periods_inc : periods_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff     <= 1'b1;
         synced_ff   <= 1'b0;
         high_sum_ff <= '0;
         low_sum_ff  <= '0;
         periods_ff  <= '0;
      end else begin
         last_ff     <= last_in;
         synced_ff   <= synced_in;
         high_sum_ff <= high_sum_in;
         low_sum_ff  <= low_sum_in;
         periods_ff  <= periods_in;
      end
   end

endmodule

[rtl/core/ppdm_queue.sv]
// Short queue of finished window sums and timeout events between the counter and the arithmetic.
module ppdm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ppdm_pkg::meas_type  push_entry,
   input  logic                pop,
   output ppdm_pkg::meas_type  head,
   output logic                empty,
   output logic                full
);

   ppdm_pkg::meas_type                 entry_ff [ppdm_pkg::QUEUE_DEPTH];
   logic [ppdm_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [ppdm_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [ppdm_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                               do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == ppdm_pkg::QCNT_W'(ppdm_pkg::QUEUE_DEPTH));
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + ppdm_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + ppdm_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + ppdm_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - ppdm_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/ppdm_divider.sv]
// Restoring unsigned divider that produces one quotient bit per cycle.
module ppdm_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  ppdm_pkg::div_req_type  div_req,
   output ppdm_pkg::div_rsp_type  div_rsp
);

   logic [ppdm_pkg::DIV_W-1:0]      quo_ff, quo_in;
   logic [ppdm_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [ppdm_pkg::DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [ppdm_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [ppdm_pkg::DIVISOR_W:0]    trial;
   logic [ppdm_pkg::DIVISOR_W:0]    diff;
   logic                            fits;

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   always_comb begin
      trial = {rem_ff, quo_ff[ppdm_pkg::DIV_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = (trial >= {1'b0, divisor_ff});

      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;

      if (div_req.start) begin
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         cnt_in     = ppdm_pkg::DIV_CNT_W'(ppdm_pkg::DIV_W);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ppdm_pkg::DIV_W-2:0], fits};
         rem_in = fits ? diff[ppdm_pkg::DIVISOR_W-1:0] : trial[ppdm_pkg::DIVISOR_W-1:0];
         cnt_in = cnt_ff - ppdm_pkg::DIV_CNT_W'(1);
         if (cnt_ff == ppdm_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

[rtl/core/ppdm_back.sv]
// Measurement arithmetic: averages, scaling to microseconds, frequency and range flags.
module ppdm_back (
   input  logic                clock,
   input  logic                reset,
   input  ppdm_pkg::cfg_type   cfg,
   input  logic                queue_empty,
   input  ppdm_pkg::meas_type  head,
   output logic                pop,
   ppdm_rsp_if.source          rsp
);

   ppdm_pkg::back_state_type        state_ff, state_in;
   logic [ppdm_pkg::SUM_WIDTH-1:0]  avg_high_ff, avg_high_in;
   logic [ppdm_pkg::SUM_WIDTH-1:0]  low_ff, low_in;
   logic [ppdm_pkg::OUT_W-1:0]      per_ff, per_in;
   logic [ppdm_pkg::OUT_W-1:0]      hi_ff, hi_in;
   logic [ppdm_pkg::OUT_W-1:0]      fq_ff, fq_in;
   logic                            timed_ff, timed_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ppdm_pkg::OUT_W-1:0]      out_freq_ff, out_freq_in;
   logic [ppdm_pkg::OUT_W-1:0]      out_per_ff, out_per_in;
   logic [ppdm_pkg::OUT_W-1:0]      out_hi_ff, out_hi_in;
   logic                            out_f1k_ff, out_f1k_in;
   logic [ppdm_pkg::BAND_W-1:0]     out_band_ff, out_band_in;
   logic                            out_p1ms_ff, out_p1ms_in;
   logic                            out_h1ms_ff, out_h1ms_in;
   logic                            out_timed_ff, out_timed_in;

   ppdm_pkg::div_req_type           div_req;
   ppdm_pkg::div_rsp_type           div_rsp;
   logic [ppdm_pkg::WINDOW_W-1:0]   w_eff;
   logic [ppdm_pkg::MUL_A_W-1:0]    mul_a;
   logic [ppdm_pkg::PROD_W-1:0]     prod;
   logic [ppdm_pkg::OUT_W-1:0]      prod_sat;
   logic [ppdm_pkg::OUT_W-1:0]      quo_sat;

   ppdm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.freq_hz         = out_freq_ff;
   assign rsp.period_us       = out_per_ff;
   assign rsp.high_us         = out_hi_ff;
   assign rsp.freq_over_1k    = out_f1k_ff;
   assign rsp.freq_band       = out_band_ff;
   assign rsp.period_over_1ms = out_p1ms_ff;
   assign rsp.high_over_1ms   = out_h1ms_ff;
   assign rsp.timed_out       = out_timed_ff;

   always_comb begin
      w_eff = (cfg.window_periods == '0) ? ppdm_pkg::WINDOW_W'(1) : cfg.window_periods;
      mul_a = (state_ff == ppdm_pkg::BK_MUL_PER)
              ? {1'b0, avg_high_ff} + {1'b0, low_ff}
              : {1'b0, avg_high_ff};
      prod  = ppdm_pkg::PROD_W'(mul_a) * ppdm_pkg::PROD_W'(cfg.tick_scale_q16);
      prod_sat = (|prod[ppdm_pkg::PROD_W-1:ppdm_pkg::FRAC_W+ppdm_pkg::OUT_W])
                 ? ppdm_pkg::OUT_MAX
                 : prod[ppdm_pkg::FRAC_W+ppdm_pkg::OUT_W-1:ppdm_pkg::FRAC_W];
      quo_sat  = (|div_rsp.quotient[ppdm_pkg::DIV_W-1:ppdm_pkg::OUT_W])
                 ? ppdm_pkg::OUT_MAX
                 : div_rsp.quotient[ppdm_pkg::OUT_W-1:0];

      state_in    = state_ff;
      avg_high_in = avg_high_ff;
      low_in      = low_ff;
      per_in      = per_ff;
      hi_in       = hi_ff;
      fq_in       = fq_ff;
      timed_in    = timed_ff;
      pop         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = ppdm_pkg::DIV_W'(head.high_sum);
      div_req.divisor  = ppdm_pkg::DIVISOR_W'(w_eff);

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_freq_in  = out_freq_ff;
      out_per_in   = out_per_ff;
      out_hi_in    = out_hi_ff;
      out_f1k_in   = out_f1k_ff;
      out_band_in  = out_band_ff;
      out_p1ms_in  = out_p1ms_ff;
      out_h1ms_in  = out_h1ms_ff;
      out_timed_in = out_timed_ff;

      case (state_ff)
         ppdm_pkg::BK_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (head.timed_out) begin
                  per_in   = '0;
                  hi_in    = '0;
                  fq_in    = '0;
                  timed_in = 1'b1;
                  state_in = ppdm_pkg::BK_FINISH;
               end else begin
                  timed_in      = 1'b0;
                  low_in        = head.low_sum;
                  div_req.start = 1'b1;
                  state_in      = ppdm_pkg::BK_DIV_HIGH;
               end
            end
         end
         ppdm_pkg::BK_DIV_HIGH: begin
            div_req.dividend = ppdm_pkg::DIV_W'(low_ff);
            if (div_rsp.done) begin
               avg_high_in   = div_rsp.quotient[ppdm_pkg::SUM_WIDTH-1:0];
               div_req.start = 1'b1;
               state_in      = ppdm_pkg::BK_DIV_LOW;
            end
         end
         ppdm_pkg::BK_DIV_LOW: begin
            if (div_rsp.done) begin
               low_in   = div_rsp.quotient[ppdm_pkg::SUM_WIDTH-1:0];
               state_in = ppdm_pkg::BK_MUL_PER;
            end
         end
         ppdm_pkg::BK_MUL_PER: begin
            per_in   = prod_sat;
            state_in = ppdm_pkg::BK_MUL_HIGH;
         end
         ppdm_pkg::BK_MUL_HIGH: begin
            hi_in = prod_sat;
            if (per_ff == '0) begin
               fq_in    = '0;
               state_in = ppdm_pkg::BK_FINISH;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = ppdm_pkg::DIV_W'(ppdm_pkg::FREQ_NUM);
               div_req.divisor  = per_ff;
               state_in         = ppdm_pkg::BK_DIV_FREQ;
            end
         end
         ppdm_pkg::BK_DIV_FREQ: begin
            if (div_rsp.done) begin
               fq_in    = quo_sat;
               state_in = ppdm_pkg::BK_FINISH;
            end
         end
         ppdm_pkg::BK_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               out_freq_in  = fq_ff;
               out_per_in   = per_ff;
               out_hi_in    = hi_ff;
               out_f1k_in   = fq_ff > ppdm_pkg::LIMIT_1K;
               out_p1ms_in  = per_ff > ppdm_pkg::LIMIT_1K;
               out_h1ms_in  = hi_ff > ppdm_pkg::LIMIT_1K;
               out_timed_in = timed_ff;
               if (timed_ff) begin
                  out_band_in = ppdm_pkg::BAND_IN;
               end else if (fq_ff < ppdm_pkg::LIMIT_1K) begin
                  out_band_in = ppdm_pkg::BAND_BELOW;
               end else if (fq_ff > ppdm_pkg::LIMIT_10K) begin
                  out_band_in = ppdm_pkg::BAND_ABOVE;
               end else begin
                  out_band_in = ppdm_pkg::BAND_IN;
               end
               state_in = ppdm_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = ppdm_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      avg_high_ff  <= avg_high_in;
      low_ff       <= low_in;
      per_ff       <= per_in;
      hi_ff        <= hi_in;
      fq_ff        <= fq_in;
      timed_ff     <= timed_in;
      out_freq_ff  <= out_freq_in;
      out_per_ff   <= out_per_in;
      out_hi_ff    <= out_hi_in;
      out_f1k_ff   <= out_f1k_in;
      out_band_ff  <= out_band_in;
      out_p1ms_ff  <= out_p1ms_in;
      out_h1ms_ff  <= out_h1ms_in;
      out_timed_ff <= out_timed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppdm_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/core/ppdm_checker.sv]
// Port-level checks on the measurement output, attached to the top level.
module ppdm_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [ppdm_pkg::OUT_W-1:0]        freq_hz,
   input  logic [ppdm_pkg::OUT_W-1:0]        period_us,
   input  logic [ppdm_pkg::OUT_W-1:0]        high_us,
   input  logic                              freq_over_1k,
   input  logic [ppdm_pkg::BAND_W-1:0]       freq_band,
   input  logic                              period_over_1ms,
   input  logic                              high_over_1ms,
   input  logic                              timed_out
);

   timeout_zero_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && timed_out |-> freq_hz == '0 && period_us == '0 && high_us == '0
         && !freq_over_1k && freq_band == ppdm_pkg::BAND_IN
         && !period_over_1ms && !high_over_1ms)
      else $error("timeout transfer carries non-zero fields");

   flags_match_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> freq_over_1k == (freq_hz > ppdm_pkg::LIMIT_1K)
         && period_over_1ms == (period_us > ppdm_pkg::LIMIT_1K)
         && high_over_1ms == (high_us > ppdm_pkg::LIMIT_1K))
      else $error("range flags disagree with measured values");

   freq_period_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !timed_out |-> (freq_hz == '0) == (period_us == '0))
      else $error("frequency and period disagree on zero");

   stall_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(freq_hz) && $stable(period_us)
         && $stable(high_us) && $stable(timed_out))
      else $error("stalled transfer changed");

   reset_quiet_a: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("transfer offered straight after reset");

endmodule

bind pulse_period_duty_meter ppdm_checker u_ppdm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .freq_hz         (rsp_chan.freq_hz),
   .period_us       (rsp_chan.period_us),
   .high_us         (rsp_chan.high_us),
   .freq_over_1k    (rsp_chan.freq_over_1k),
   .freq_band       (rsp_chan.freq_band),
   .period_over_1ms (rsp_chan.period_over_1ms),
   .high_over_1ms   (rsp_chan.high_over_1ms),
   .timed_out       (rsp_chan.timed_out)
);
